// File: rtl/core/u8lt_pkg.sv
// Shared types, widths and byte-class constants for the UTF-8 decoder with line tracking.
package u8lt_pkg;

    localparam int unsigned ST_W   = 3;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned LINE_W = 24;
    localparam int unsigned COL_W  = 16;
    localparam int unsigned OFS_W  = 32;

    localparam int unsigned LINE_BITS_DEF   = 24;
    localparam int unsigned COLUMN_BITS_DEF = 16;
    localparam int unsigned OFFSET_BITS_DEF = 32;

    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] PAT_LEAD2  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] PAT_LEAD3  = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] PAT_LEAD4  = 8'hF0;
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] PAT_CONT   = 8'h80;
    localparam logic [7:0] MAX_ASCII  = 8'h7F;

    localparam logic [CP_W-1:0] CP_NEWLINE = 21'h00000A;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_LEAD = 3'd1,
        ST_BAD_CONT = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_END      = 3'd4
    } t_status;

    typedef struct packed {
        logic              has;
        t_status           status;
        logic [CP_W-1:0]   code_point;
        logic [LEN_W-1:0]  byte_length;
    } t_result;

endpackage

// File: rtl/core/u8lt_intf.sv
// Valid/ready channel interfaces for the input byte words and the decoded result words.
interface u8lt_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface u8lt_out_if;
    import u8lt_pkg::*;
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [CP_W-1:0]   code_point;
    logic [LEN_W-1:0]  byte_length;
    logic [LINE_W-1:0] line_number;
    logic [COL_W-1:0]  column;
    logic [OFS_W-1:0]  line_start_offset;

    modport source (output valid, output status, output code_point, output byte_length,
                    output line_number, output column, output line_start_offset,
                    input ready);
    modport sink   (input valid, input status, input code_point, input byte_length,
                    input line_number, input column, input line_start_offset,
                    output ready);
endinterface

// File: rtl/core/utf8_decoder_line_tracker.sv
// Top level of the UTF-8 decoder with line tracking: input register, decode and result register.
//
//  Channel  Dir  Word fields
//  i_in     in   op, data_byte
//  o_out    out  status, code_point, byte_length, line_number, column, line_start_offset
//
// One byte word is accepted per cycle unless a stalled result holds the decode stage.
// The word passes an input register, one pass of decode logic and a result register.
// Reset clears the input and result stages, the partial sequence, column and offsets; line is 1.
// A stalled result holds the decode stage only when that stage holds a word that has a result.
module utf8_decoder_line_tracker #(
    parameter int unsigned LINE_BITS   = u8lt_pkg::LINE_BITS_DEF,
    parameter int unsigned COLUMN_BITS = u8lt_pkg::COLUMN_BITS_DEF,
    parameter int unsigned OFFSET_BITS = u8lt_pkg::OFFSET_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    u8lt_in_if.sink    i_in,
    u8lt_out_if.source o_out
);
    import u8lt_pkg::*;

    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;

    logic              r_out_valid;
    logic [ST_W-1:0]   r_status;
    logic [CP_W-1:0]   r_cp;
    logic [LEN_W-1:0]  r_blen;
    logic [LINE_W-1:0] r_line;
    logic [COL_W-1:0]  r_col;
    logic [OFS_W-1:0]  r_lstart;

    t_result                res;
    logic [LINE_BITS-1:0]   dec_line;
    logic [COLUMN_BITS-1:0] dec_col;
    logic [OFFSET_BITS-1:0] dec_lstart;

    logic out_free;
    logic step;
    logic in_take;

    assign out_free = !r_out_valid || o_out.ready;
    assign step     = r_in_valid && (!res.has || out_free);
    assign in_take  = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || step;

    u8lt_decode #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_op     (r_in_op),
        .i_byte   (r_in_byte),
        .o_res    (res),
        .o_line   (dec_line),
        .o_col    (dec_col),
        .o_lstart (dec_lstart)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op   <= i_in.op;
            r_in_byte <= i_in.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res.has) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.has) begin
            r_status <= res.status;
            r_cp     <= res.code_point;
            r_blen   <= res.byte_length;
            r_line   <= LINE_W'(dec_line);
            r_col    <= COL_W'(dec_col);
            r_lstart <= OFS_W'(dec_lstart);
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.status            = r_status;
    assign o_out.code_point        = r_cp;
    assign o_out.byte_length       = r_blen;
    assign o_out.line_number       = r_line;
    assign o_out.column            = r_col;
    assign o_out.line_start_offset = r_lstart;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("input not ready with an empty decode stage");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && res.has && r_out_valid && !o_out.ready |=> r_in_valid)
        else $error("decode stage word lost during a result stall");

    a_ok_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == ST_OK) |-> (r_blen != '0))
        else $error("decoded character with zero byte length");

endmodule

// File: rtl/core/u8lt_decode.sv
// Sequence assembly state, position counters and the per-word decode logic.
module u8lt_decode #(
    parameter int unsigned LINE_BITS   = u8lt_pkg::LINE_BITS_DEF,
    parameter int unsigned COLUMN_BITS = u8lt_pkg::COLUMN_BITS_DEF,
    parameter int unsigned OFFSET_BITS = u8lt_pkg::OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic                   i_op,
    input  logic [7:0]             i_byte,
    output u8lt_pkg::t_result      o_res,
    output logic [LINE_BITS-1:0]   o_line,
    output logic [COLUMN_BITS-1:0] o_col,
    output logic [OFFSET_BITS-1:0] o_lstart
);
    import u8lt_pkg::*;

    logic [CP_W-1:0]        r_acc, n_acc;
    logic [1:0]             r_rem, n_rem;
    logic [LEN_W-1:0]       r_len, n_len;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [COLUMN_BITS-1:0] r_col, n_col;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_lstart, n_lstart;

    logic             finish;
    logic [CP_W-1:0]  fin_cp;
    logic [LEN_W-1:0] fin_len;
    logic [CP_W-1:0]  shifted;

    assign shifted = {r_acc[CP_W-7:0], i_byte[5:0]};

    always_comb begin
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_len    = r_len;
        n_line   = r_line;
        n_col    = r_col;
        n_pos    = r_pos;
        n_lstart = r_lstart;
        finish   = 1'b0;
        fin_cp   = '0;
        fin_len  = '0;
        o_res    = '{has: 1'b0, status: ST_OK, code_point: '0, byte_length: '0};

        if (i_op == OP_END) begin
            o_res.has = 1'b1;
            if (r_len != '0) begin
                o_res.status = ST_TRUNC;
                n_acc = '0;
                n_rem = '0;
                n_len = '0;
            end else begin
                o_res.status = ST_END;
            end
        end else begin
            n_pos = (&r_pos) ? r_pos : r_pos + 1'b1;
            if (r_len == '0) begin
                if (i_byte <= MAX_ASCII) begin
                    finish  = 1'b1;
                    fin_cp  = CP_W'(i_byte);
                    fin_len = LEN_W'(1);
                end else if ((i_byte & MASK_LEAD2) == PAT_LEAD2) begin
                    n_acc = CP_W'(i_byte[4:0]);
                    n_len = LEN_W'(2);
                    n_rem = 2'd1;
                end else if ((i_byte & MASK_LEAD3) == PAT_LEAD3) begin
                    n_acc = CP_W'(i_byte[3:0]);
                    n_len = LEN_W'(3);
                    n_rem = 2'd2;
                end else if ((i_byte & MASK_LEAD4) == PAT_LEAD4) begin
                    n_acc = CP_W'(i_byte[2:0]);
                    n_len = LEN_W'(4);
                    n_rem = 2'd3;
                end else begin
                    o_res.has    = 1'b1;
                    o_res.status = ST_BAD_LEAD;
                end
            end else if ((i_byte & MASK_CONT) != PAT_CONT) begin
                o_res.has    = 1'b1;
                o_res.status = ST_BAD_CONT;
                n_acc = '0;
                n_rem = '0;
                n_len = '0;
            end else if (r_rem == 2'd1) begin
                finish  = 1'b1;
                fin_cp  = shifted;
                fin_len = r_len;
            end else begin
                n_acc = shifted;
                n_rem = r_rem - 2'd1;
            end

            if (finish) begin
                n_acc = '0;
                n_rem = '0;
                n_len = '0;
                o_res = '{has: 1'b1, status: ST_OK, code_point: fin_cp, byte_length: fin_len};
                if (fin_cp == CP_NEWLINE) begin
                    n_line   = (&r_line) ? r_line : r_line + 1'b1;
                    n_lstart = n_pos;
                    n_col    = '0;
                end else begin
                    n_col = (&r_col) ? r_col : r_col + 1'b1;
                end
            end
        end
    end

    assign o_line   = n_line;
    assign o_col    = n_col;
    assign o_lstart = n_lstart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_rem    <= '0;
            r_len    <= '0;
            r_line   <= LINE_BITS'(1);
            r_col    <= '0;
            r_pos    <= '0;
            r_lstart <= '0;
        end else if (i_step) begin
            r_acc    <= n_acc;
            r_rem    <= n_rem;
            r_len    <= n_len;
            r_line   <= n_line;
            r_col    <= n_col;
            r_pos    <= n_pos;
            r_lstart <= n_lstart;
        end
    end

    a_rem_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem != 2'd0) |-> (r_len != '0) && (LEN_W'(r_rem) < r_len))
        else $error("continuation count without a sequence in progress");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len <= LEN_W'(4)) && (r_len != LEN_W'(1)))
        else $error("sequence length out of range");

    a_line_start_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lstart <= r_pos) && (r_line != '0))
        else $error("line start beyond byte position or line counter zero");

endmodule

// File: tb/utf8_decoder_line_tracker_tb.sv
// Self-checking testbench for the UTF-8 decoder with line tracking: it predicts every result word and compares it.
module utf8_decoder_line_tracker_tb;
    import u8lt_pkg::*;

    typedef struct {
        t_status           status;
        logic [CP_W-1:0]   code_point;
        logic [LEN_W-1:0]  byte_length;
        logic [LINE_W-1:0] line_number;
        logic [COL_W-1:0]  column;
        logic [OFS_W-1:0]  line_start_offset;
    } t_char_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8lt_in_if  byte_ch ();
    u8lt_out_if char_ch ();

    utf8_decoder_line_tracker i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (char_ch)
    );

    always #1 i_clk = ~i_clk;

    t_char_result expected_chars [$];
    int unsigned  error_count = 0;
    int unsigned  result_count = 0;
    bit           sender_idles = 1'b1;
    bit           receiver_stalls = 1'b1;

    logic [CP_W-1:0]   part_cp   = '0;
    logic [1:0]        cont_left = '0;
    logic [LEN_W-1:0]  seq_len   = '0;
    logic [LINE_W-1:0] line_cnt  = LINE_W'(1);
    logic [COL_W-1:0]  col_cnt   = '0;
    logic [OFS_W-1:0]  byte_pos  = '0;
    logic [OFS_W-1:0]  line_base = '0;

    function automatic bit decode_word(input logic op, input logic [7:0] b,
                                       output t_char_result res);
        bit               has  = 1'b0;
        bit               done = 1'b0;
        t_status          st   = ST_OK;
        logic [CP_W-1:0]  cp   = '0;
        logic [LEN_W-1:0] len  = '0;
        if (op == OP_END) begin
            if (seq_len != 0) begin
                st = ST_TRUNC;
            end else begin
                st = ST_END;
            end
            part_cp = '0;
            cont_left = '0;
            seq_len = '0;
            has = 1'b1;
        end else begin
            if (byte_pos != '1) begin
                byte_pos = byte_pos + 1'b1;
            end
            if (seq_len == 0) begin
                if (b <= MAX_ASCII) begin
                    part_cp = CP_W'(b);
                    seq_len = LEN_W'(1);
                    done = 1'b1;
                end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
                    part_cp = CP_W'(b[4:0]);
                    seq_len = LEN_W'(2);
                    cont_left = 2'd1;
                end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
                    part_cp = CP_W'(b[3:0]);
                    seq_len = LEN_W'(3);
                    cont_left = 2'd2;
                end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
                    part_cp = CP_W'(b[2:0]);
                    seq_len = LEN_W'(4);
                    cont_left = 2'd3;
                end else begin
                    st = ST_BAD_LEAD;
                    has = 1'b1;
                end
            end else if ((b & MASK_CONT) != PAT_CONT) begin
                part_cp = '0;
                cont_left = '0;
                seq_len = '0;
                st = ST_BAD_CONT;
                has = 1'b1;
            end else begin
                part_cp = {part_cp[CP_W-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                done = (cont_left == 0);
            end
            if (done) begin
                cp = part_cp;
                len = seq_len;
                part_cp = '0;
                cont_left = '0;
                seq_len = '0;
                if (cp == CP_NEWLINE) begin
                    if (line_cnt != '1) begin
                        line_cnt = line_cnt + 1'b1;
                    end
                    line_base = byte_pos;
                    col_cnt = '0;
                end else if (col_cnt != '1) begin
                    col_cnt = col_cnt + 1'b1;
                end
                has = 1'b1;
            end
        end
        res = '{st, cp, len, line_cnt, col_cnt, line_base};
        return has;
    endfunction

    function automatic void encode_char(input logic [CP_W-1:0] cp, input int len,
                                        output logic [7:0] seq [4]);
        case (len)
            1: begin
                seq[0] = {1'b0, cp[6:0]};
            end
            2: begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3: begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default: begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at result %0d: %s", result_count, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_char_result want;
        if (i_rst_n && char_ch.valid && char_ch.ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = expected_chars.pop_front();
                check_field("status", 32'(char_ch.status), 32'(want.status));
                check_field("code_point", 32'(char_ch.code_point), 32'(want.code_point));
                check_field("byte_length", 32'(char_ch.byte_length), 32'(want.byte_length));
                check_field("line_number", 32'(char_ch.line_number), 32'(want.line_number));
                check_field("column", 32'(char_ch.column), 32'(want.column));
                check_field("line_start_offset", char_ch.line_start_offset,
                            want.line_start_offset);
            end
            result_count++;
        end
    end

    initial begin : drive_ready
        char_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (receiver_stalls && $urandom_range(0, 5) == 0) begin
                char_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            char_ch.ready <= 1'b1;
        end
    end

    task automatic send_word(input logic op, input logic [7:0] b);
        t_char_result res;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.op <= op;
        byte_ch.data_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) begin
            @(posedge i_clk);
        end
        if (decode_word(op, b, res)) begin
            expected_chars.push_back(res);
        end
    endtask

    task automatic wait_for_results();
        byte_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_chars.size() != 0);
    endtask

    task automatic send_random_piece();
        logic [CP_W-1:0] cp;
        logic [7:0]      seq [4];
        logic [7:0]      b;
        int              len;
        int              kept;
        int              pick;
        pick = $urandom_range(0, 9);
        cp = CP_W'($urandom);
        len = $urandom_range(1, 4);
        if (pick < 7) begin
            if ($urandom_range(0, 7) == 0) begin
                cp = CP_NEWLINE;
                len = 1;
            end
            encode_char(cp, len, seq);
            for (int i = 0; i < len; i++) begin
                send_word(OP_DATA, seq[i]);
            end
        end else if (pick == 7) begin
            send_word(OP_DATA, 8'($urandom));
        end else if (pick == 8) begin
            send_word(OP_END, 8'($urandom));
        end else begin
            len = $urandom_range(2, 4);
            encode_char(cp, len, seq);
            kept = $urandom_range(1, len - 1);
            for (int i = 0; i < kept; i++) begin
                send_word(OP_DATA, seq[i]);
            end
            if ($urandom_range(0, 1) == 0) begin
                send_word(OP_END, 8'($urandom));
            end else begin
                b = 8'($urandom);
                if (b[7:6] == 2'b10) begin
                    b[6] = 1'b1;
                end
                send_word(OP_DATA, b);
            end
        end
    endtask

    task automatic test_directed();
        logic [8:0] words [$] = '{
            {OP_DATA, 8'h00}, {OP_DATA, 8'h7F}, {OP_DATA, 8'h0A},
            {OP_DATA, 8'hC2}, {OP_DATA, 8'h80},
            {OP_DATA, 8'hC0}, {OP_DATA, 8'h8A},
            {OP_DATA, 8'hEF}, {OP_DATA, 8'hBF}, {OP_DATA, 8'hBF},
            {OP_DATA, 8'hF7}, {OP_DATA, 8'hBF}, {OP_DATA, 8'hBF}, {OP_DATA, 8'hBF},
            {OP_DATA, 8'h80}, {OP_DATA, 8'hBF}, {OP_DATA, 8'hF8}, {OP_DATA, 8'hFF},
            {OP_DATA, 8'hC3}, {OP_DATA, 8'h41},
            {OP_DATA, 8'hE2}, {OP_DATA, 8'hC0},
            {OP_DATA, 8'hF1}, {OP_DATA, 8'h80}, {OP_END, 8'hFF},
            {OP_END, 8'h00}
        };
        foreach (words[i]) begin
            send_word(words[i][8], words[i][7:0]);
        end
    endtask

    task automatic test_random(input int pieces);
        for (int i = 0; i < pieces; i++) begin
            send_random_piece();
            if (i == pieces / 2) begin
                wait_for_results();
            end
        end
    endtask

    task automatic test_back_to_back(input int pieces);
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
        for (int i = 0; i < pieces; i++) begin
            send_random_piece();
        end
    endtask

    initial begin : stimulus
        i_rst_n <= 1'b0;
        byte_ch.valid <= 1'b0;
        byte_ch.op <= OP_DATA;
        byte_ch.data_byte <= 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(320);
        test_back_to_back(150);

        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/u8lt_pkg.sv
rtl/core/u8lt_intf.sv
rtl/core/u8lt_decode.sv
rtl/core/utf8_decoder_line_tracker.sv
tb/utf8_decoder_line_tracker_tb.sv
